### hw/rtl/sha256_pkg.sv
// Package: SHA-256 round constants, initial hash values, padding constants, command types and a rotate helper.
`default_nettype none
package sha256_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [31:0] RoundK [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   localparam logic [31:0] InitialH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [7:0] PadMarker = 8'h80;
   localparam logic [5:0] LengthSlot = 6'd56;

   // classified item handed from front to back
   typedef enum logic [1:0] {
      CMD_IDLE  = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_END   = 2'd2,
      CMD_BOTH  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

### hw/rtl/sha256_if.sv
// Interfaces: valid/ready channels for input bytes and digest words.
`default_nettype none
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        word_last;
   modport source (output valid, digest_word, word_last, input ready);
   modport sink (input valid, digest_word, word_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// Top level: streaming SHA-256 hasher, front queue plus compression core.
// Throughput: one byte transaction a cycle while the queue has room; a full block
//   then passes through the round engine (load, 64 rounds, chain add).
// Output: after the core takes an end transaction, the first digest word follows
//   padding (one byte a cycle) and one or two compressions.
// Reset: synchronous; chain words return to the initial hash, counts clear.
`default_nettype none
module sha256_stream_hasher
   import sha256_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   // classify and buffer incoming transactions
   sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req, .cmd, .cmd_valid, .cmd_ready
   );

   // pad, compress and emit digest words
   sha256_core u_core (
      .clock, .reset, .cmd, .cmd_valid, .cmd_ready, .rsp
   );

`ifndef NO_ASSERTIONS
   // hold an offered digest word until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.digest_word))
      else $error("digest word dropped under stall");
   // the core never shows ready for a command while a digest word is offered
   a_cmd_gate: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !rsp.valid)
      else $error("core idle while output pending");
`endif
endmodule
`default_nettype wire

### hw/rtl/sha256_front.sv
// Front end: classify input transactions and queue them for the core.
`default_nettype none
module sha256_front
   import sha256_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   sha256_req_if.sink   req,
   output cmd_type      cmd,
   output logic         cmd_valid,
   input  wire logic    cmd_ready
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type        mem [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           push, pop;
   cmd_type        item;

   always_comb begin
      item.data = req.data_byte;
      item.kind = cmd_kind_type'({req.end_of_message, req.byte_present});
   end

   assign req.ready = (cnt_ff != (AW+1)'(DEPTH));
   // idle transactions are dropped here
   assign push = req.valid && req.ready && (item.kind != CMD_IDLE);
   assign cmd_valid = (cnt_ff != '0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = mem[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= item;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/sha256_core.sv
// Core: block buffer, padding sequencer, 64-round compression and digest output.
`default_nettype none
module sha256_core
   import sha256_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   sha256_rsp_if.source rsp
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LEN   = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_ADD   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  w_ff [16];         // block words, then schedule window
   logic [31:0]  h_ff [8];
   logic [31:0]  v_ff [8];
   logic [5:0]   fill_ff;
   logic [60:0]  count_ff;
   logic [5:0]   round_ff;
   logic [2:0]   len_ff;
   logic         fin_ff;            // message end taken, digest owed
   logic         padded_ff;         // marker placed
   logic         spill_ff;          // marker block has no room for the length
   logic         spill_now;
   logic [2:0]   oidx_ff;
   logic         ovalid_ff;
   logic [31:0]  oword_ff;
   logic [63:0]  bits;
   logic [31:0]  wcur, s0, s1, t1, t2, wnext;

   assign bits = {count_ff, 3'b000};
   assign cmd_ready = (state_ff == ST_IDLE);
   // a marker at the length slot or later pushes the length into one more block
   assign spill_now = padded_ff ? spill_ff : (fill_ff >= LengthSlot);

   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnext = w_ff[0] + s0 + w_ff[9] + s1;
      wcur = w_ff[0];
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + RoundK[round_ff] + wcur;
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.digest_word = oword_ff;
   assign rsp.word_last = ovalid_ff && (oidx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            if (cmd.kind == CMD_BYTE || cmd.kind == CMD_BOTH) begin
               if (fill_ff == 6'd63) state_in = ST_LOAD;
               else if (cmd.kind == CMD_BOTH) state_in = ST_PAD;
            end else state_in = ST_PAD;
         end
         ST_PAD: begin
            if (fill_ff == 6'd63 && spill_now) state_in = ST_LOAD;
            else if (fill_ff == 6'd55 && !spill_now) state_in = ST_LEN;
            else state_in = ST_PAD;
         end
         ST_LEN: state_in = (len_ff == 3'd7) ? ST_LOAD : ST_LEN;
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: state_in = (round_ff == 6'd63) ? ST_ADD : ST_ROUND;
         ST_ADD: begin
            if (!fin_ff) state_in = ST_IDLE;
            else if (!padded_ff || spill_ff) state_in = ST_PAD;
            else state_in = ST_OUT;
         end
         ST_OUT: state_in = (ovalid_ff && rsp.ready && oidx_ff == 3'd7) ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // write one byte into the word buffer at the fill position
   function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] k,
                                       input logic [7:0] b);
      logic [31:0] r;
      r = w;
      r[8*(3-k) +: 8] = b;
      put = r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         count_ff  <= '0;
         fin_ff    <= 1'b0;
         padded_ff <= 1'b0;
         spill_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
         oidx_ff   <= '0;
         round_ff  <= '0;
         len_ff    <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitialH[i];
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (cmd_valid) begin
               fin_ff <= cmd.kind[1];
               padded_ff <= 1'b0;
               spill_ff <= 1'b0;
               if (cmd.kind[0]) begin
                  w_ff[fill_ff[5:2]] <= put(w_ff[fill_ff[5:2]], fill_ff[1:0], cmd.data);
                  fill_ff  <= fill_ff + 1'b1;
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_PAD: begin
               // first pad cycle places the marker, later ones zero fill
               if (!padded_ff) begin
                  w_ff[fill_ff[5:2]] <= put(w_ff[fill_ff[5:2]], fill_ff[1:0], PadMarker);
                  padded_ff <= 1'b1;
                  fill_ff <= fill_ff + 1'b1;
                  spill_ff <= (fill_ff >= LengthSlot);
               end else begin
                  w_ff[fill_ff[5:2]] <= put(w_ff[fill_ff[5:2]], fill_ff[1:0], 8'h00);
                  fill_ff <= fill_ff + 1'b1;
               end
               len_ff <= '0;
            end
            ST_LEN: begin
               w_ff[fill_ff[5:2]] <= put(w_ff[fill_ff[5:2]], fill_ff[1:0],
                                         bits[8*(7-len_ff) +: 8]);
               fill_ff <= fill_ff + 1'b1;
               len_ff <= len_ff + 1'b1;
            end
            ST_LOAD: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               round_ff <= '0;
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= (round_ff < 6'd48) ? wnext : w_ff[0];
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 1'b1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               fill_ff <= '0;
               // marker went into the previous block; owe a zero/length block
               spill_ff <= 1'b0;
               oidx_ff <= '0;
            end
            ST_OUT: begin
               if (!ovalid_ff) begin
                  ovalid_ff <= 1'b1;
                  oword_ff <= h_ff[oidx_ff];
               end else if (rsp.ready) begin
                  if (oidx_ff == 3'd7) begin
                     ovalid_ff <= 1'b0;
                     fill_ff   <= '0;
                     count_ff  <= '0;
                     for (int i = 0; i < 8; i++) h_ff[i] <= InitialH[i];
                  end else begin
                     oword_ff <= h_ff[oidx_ff + 1'b1];
                  end
                  oidx_ff <= oidx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### test/tb_sha256_stream_hasher.sv
// Testbench for the streaming SHA-256 hasher: directed and random messages checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_stream_hasher;
   import sha256_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        word_last;
   } digest_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha256_req_if req ();
   sha256_rsp_if rsp ();

   sha256_stream_hasher uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #5 clock = ~clock;

   // Predictor state: chaining words, partial block, fill and byte count.
   logic [31:0] chain_h [8];
   logic [7:0]  blk [64];
   int unsigned blk_fill;
   logic [60:0] msg_bytes;

   byte_item_type   pending_bytes [$];
   digest_item_type expected_digest [$];
   int  mismatches = 0;

   // Receiver control: long hold-off request, counted in the monitor process.
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   // Sender control: burst and gap counters.
   int  burst_left = 0;
   int  gap_left = 0;
   bit  drain_request = 1'b0;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) chain_h[i] = InitialH[i];
      blk_fill  = 0;
      msg_bytes = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wr, t1, t2, x15, x2, s0, s1;
      for (int r = 0; r < 16; r++)
         w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int i = 0; i < 8; i++) v[i] = chain_h[i];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            x15 = w[(r-15) & 15];
            x2  = w[(r-2) & 15];
            s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
            s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
            wr  = w[r & 15] + s0 + w[(r-7) & 15] + s1;
            w[r & 15] = wr;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + wr;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] += v[i];
   endfunction

   // Advance the predictor by one accepted transaction; queue any digest words.
   function automatic void predict_digest(input byte_item_type it);
      logic [63:0] bit_len;
      digest_item_type d;
      if (it.byte_present) begin
         blk[blk_fill] = it.data_byte;
         blk_fill++;
         msg_bytes++;
         if (blk_fill == 64) begin
            compress_block();
            blk_fill = 0;
         end
      end
      if (!it.end_of_message) return;
      bit_len = {msg_bytes, 3'b000};
      blk[blk_fill] = PadMarker;
      blk_fill++;
      if (blk_fill > LengthSlot) begin
         for (int i = blk_fill; i < 64; i++) blk[i] = 8'h00;
         compress_block();
         blk_fill = 0;
      end
      for (int i = blk_fill; i < LengthSlot; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[LengthSlot + i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         d.digest_word = chain_h[i];
         d.word_last   = (i == 7);
         expected_digest.push_back(d);
      end
      restart_message();
   endfunction

   function automatic void add_item(input logic [7:0] b, input bit present, input bit eom);
      byte_item_type it;
      it.data_byte      = b;
      it.byte_present   = present;
      it.end_of_message = eom;
      pending_bytes.push_back(it);
   endfunction

   // Queue one message of the given length with random bytes; sprinkle idle items.
   function automatic void add_message(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) add_item(8'($urandom), 1'b0, 1'b0);
         if (i == len - 1 && $urandom_range(0, 1))
            add_item(8'($urandom), 1'b1, 1'b1);
         else
            add_item(8'($urandom), 1'b1, 1'b0);
      end
      if (len == 0 || pending_bytes[$].end_of_message == 1'b0)
         add_item(8'($urandom), 1'b0, 1'b1);
   endfunction

   // Driver: offer transactions in bursts with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req.valid          <= 1'b0;
         req.data_byte      <= '0;
         req.byte_present   <= 1'b0;
         req.end_of_message <= 1'b0;
      end else begin
         automatic bit fired = req.valid && req.ready;
         automatic bit can_send;
         if (fired) begin
            predict_digest(pending_bytes.pop_front());
            if (burst_left > 0) burst_left--;
         end
         if (gap_left > 0) gap_left--;
         if (burst_left == 0 && gap_left == 0) begin
            if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
         end
         can_send = pending_bytes.size() > 0 && gap_left == 0 && !drain_request;
         if (can_send) begin
            req.valid          <= 1'b1;
            req.data_byte      <= pending_bytes[0].data_byte;
            req.byte_present   <= pending_bytes[0].byte_present;
            req.end_of_message <= pending_bytes[0].end_of_message;
         end else if (fired || !req.valid) begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: stall on its own pattern, check each accepted digest word.
   int rsp_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_digest.size() == 0) begin
               $error("unexpected digest word %08h", rsp.digest_word);
               mismatches++;
            end else begin
               automatic digest_item_type e = expected_digest.pop_front();
               if (rsp.digest_word !== e.digest_word) begin
                  $error("digest_word expected %08h actual %08h",
                         e.digest_word, rsp.digest_word);
                  mismatches++;
               end
               if (rsp.word_last !== e.word_last) begin
                  $error("word_last expected %0b actual %0b",
                         e.word_last, rsp.word_last);
                  mismatches++;
               end
            end
         end
         if (hold_request && hold_left == 0) begin
            hold_left = 600;
            hold_request = 1'b0;
         end
         rsp_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if ((rsp_phase / 200) % 2 == 0) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   initial begin
      int n_random;
      restart_message();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, idle then empty, single extremes, padding edges.
      add_item(8'hFF, 1'b0, 1'b1);
      add_item(8'h00, 1'b0, 1'b0);
      add_item(8'hA5, 1'b0, 1'b1);
      add_item(8'h00, 1'b1, 1'b1);
      add_item(8'hFF, 1'b1, 1'b1);
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      add_item(8'h55, 1'b1, 1'b0);
      add_item(8'hAA, 1'b1, 1'b1);
      add_message(55);
      add_message(64);

      // Random short messages.
      n_random = 0;
      while (n_random < 30) begin
         automatic int len = $urandom_range(0, 12);
         add_message(len);
         n_random += len + 1;
      end

      // Long receiver hold-off while the sender keeps offering.
      wait (pending_bytes.size() < 150);
      hold_request = 1'b1;
      wait (!hold_request);

      // Sender pause until every expected digest word has arrived.
      wait (pending_bytes.size() < 60);
      drain_request = 1'b1;
      wait (expected_digest.size() == 0);
      drain_request = 1'b0;

      wait (pending_bytes.size() == 0 && !(req.valid === 1'b1));
      wait (expected_digest.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_digest.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
